// File: src/lrukc_pkg.sv
// lrukc_pkg: shared types and constants for the keyed rate cache
// field widths, request codes and the request beat structure
// no dependencies
package lrukc_pkg;

  localparam int KEY_W      = 24;
  localparam int PIDX_W     = 4;
  localparam int RATE_W     = 64;

  localparam int ENTRIES_DEF = 16;
  localparam int PATHS_DEF   = 16;

  // request type codes
  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_SET  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [KEY_W-1:0]  entry_key;
    logic [PIDX_W-1:0] path_index;
    logic [RATE_W-1:0] rate_in;
  } req_t;

  // flags carried alongside the memory read into the result stage
  typedef struct packed {
    logic found;
    logic is_read;
    logic evicted;
  } rsp_flags_t;

endpackage

// File: src/lrukc_if.sv
// request and response channel interfaces for the keyed rate cache
// valid/ready handshake with the payload fields of one beat
// depends on lrukc_pkg
interface lrukc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [lrukc_pkg::KEY_W-1:0]  entry_key;
  logic [lrukc_pkg::PIDX_W-1:0] path_index;
  logic [lrukc_pkg::RATE_W-1:0] rate_in;

  modport source (output valid, req_type, entry_key, path_index, rate_in, input ready);
  modport sink   (input valid, req_type, entry_key, path_index, rate_in, output ready);
endinterface

interface lrukc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        key_found;
  logic                        rate_present;
  logic [lrukc_pkg::RATE_W-1:0] rate_out;
  logic                        evicted;

  modport source (output valid, key_found, rate_present, rate_out, evicted, input ready);
  modport sink   (input valid, key_found, rate_present, rate_out, evicted, output ready);
endinterface

// File: src/lrukc_dir.sv
// lrukc_dir: line directory with parallel key match and lru age ranks
// picks the hit line or the line to allocate and commits the update
// depends on lrukc_pkg
module lrukc_dir #(
  parameter int ENTRIES = lrukc_pkg::ENTRIES_DEF,
  parameter int LINE_W  = $clog2(ENTRIES)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       is_set,
  input  logic [lrukc_pkg::KEY_W-1:0] key,
  output logic                       hit,
  output logic                       evict,
  output logic [LINE_W-1:0]          line
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic [lrukc_pkg::KEY_W-1:0] keys [ENTRIES];
  logic [LINE_W-1:0]           rank [ENTRIES];
  logic [ENTRIES-1:0]          valid;
  logic [CNT_W-1:0]            fill;

  logic [ENTRIES-1:0] match;
  logic [LINE_W-1:0]  hit_line;
  logic [LINE_W-1:0]  hit_rank;
  logic [LINE_W-1:0]  lru_line;
  logic [LINE_W-1:0]  alloc_line;
  logic               full;

  always_comb begin
    hit_line = '0;
    hit_rank = '0;
    lru_line = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == key);
      if (match[i]) begin
        hit_line = hit_line | LINE_W'(i);
        hit_rank = hit_rank | rank[i];
      end
      // ranks of valid lines are distinct, so the oldest one is unique
      if (valid[i] && (rank[i] == LINE_W'(ENTRIES - 1))) begin
        lru_line = lru_line | LINE_W'(i);
      end
    end
  end

  // lines fill from index zero upwards and are never freed
  assign full       = (fill == CNT_W'(ENTRIES));
  assign alloc_line = full ? lru_line : fill[LINE_W-1:0];
  assign hit        = |match;
  assign evict      = is_set && !hit && full;
  assign line       = hit ? hit_line : alloc_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fill  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (adv) begin
      if (!is_set && hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (LINE_W'(i) == hit_line) begin
            rank[i] <= '0;
          end else if (valid[i] && (rank[i] < hit_rank)) begin
            rank[i] <= rank[i] + LINE_W'(1);
          end
        end
      end else if (is_set && !hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (LINE_W'(i) == alloc_line) begin
            rank[i]  <= '0;
            valid[i] <= 1'b1;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + LINE_W'(1);
          end
        end
        if (!full) begin
          fill <= fill + CNT_W'(1);
        end
      end
    end
  end

  // keys need no reset, a key is only compared while its line is valid
  always_ff @(posedge clk) begin
    if (adv && is_set && !hit) begin
      keys[alloc_line] <= key;
    end
  end

endmodule

// File: src/lrukc_store.sv
// lrukc_store: rate word memory and per-line set-mark rows
// one synchronous access per beat, read data registered
// depends on lrukc_pkg
module lrukc_store #(
  parameter int ENTRIES = lrukc_pkg::ENTRIES_DEF,
  parameter int PATHS   = lrukc_pkg::PATHS_DEF,
  parameter int LINE_W  = $clog2(ENTRIES)
) (
  input  logic                        clk,
  input  logic                        adv,
  input  lrukc_pkg::req_t             req,
  input  logic                        hit,
  input  logic [LINE_W-1:0]           line,
  output logic [lrukc_pkg::RATE_W-1:0] rd_word,
  output logic                        rd_mark
);

  localparam int PATH_W   = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int ROW_W    = 1 << PATH_W;
  localparam int DEPTH    = ENTRIES * ROW_W;
  localparam int PCMP_W   = ((PATH_W > lrukc_pkg::PIDX_W) ? PATH_W : lrukc_pkg::PIDX_W) + 1;

  logic [lrukc_pkg::RATE_W-1:0] words [DEPTH];
  logic [ROW_W-1:0]             marks [ENTRIES];

  logic [PATH_W-1:0]        pidx;
  logic                     path_ok;
  logic                     is_set;
  logic [LINE_W+PATH_W-1:0] waddr;
  logic [ROW_W-1:0]         onehot;
  logic [ROW_W-1:0]         mmask;
  logic [ROW_W-1:0]         mdata;

  assign pidx    = PATH_W'(req.path_index);
  assign path_ok = PCMP_W'(req.path_index) < PCMP_W'(PATHS);
  assign is_set  = (req.req_type == lrukc_pkg::REQ_SET);
  assign waddr   = {line, pidx};
  assign onehot  = ROW_W'(1) << pidx;

  // a fresh line rewrites its whole mark row, a present line sets one bit
  always_comb begin
    if (!hit) begin
      mmask = '1;
      mdata = path_ok ? onehot : '0;
    end else begin
      mmask = path_ok ? onehot : '0;
      mdata = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_set) begin
      for (int b = 0; b < ROW_W; b++) begin
        if (mmask[b]) begin
          marks[line][b] <= mdata[b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_set && path_ok) begin
      words[waddr] <= req.rate_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_word <= words[waddr];
      rd_mark <= path_ok && marks[line][pidx];
    end
  end

endmodule

// File: src/lru_keyed_rate_cache.sv
// lru_keyed_rate_cache: fully associative keyed cache of rate words, lru replacement
// a result beat is offered from the result stage once the lookup stage passes it on
// throughput: one request per cycle while rsp is not stalled; its directory update
//   and its one synchronous rate/mark memory access complete in its lookup cycle
// reset: clears line valid bits, age ranks, fill count and both pipeline stages;
//   the memories need no clearing pass as unwritten data never reaches a response
module lru_keyed_rate_cache #(
  parameter int ENTRIES = lrukc_pkg::ENTRIES_DEF,
  parameter int PATHS   = lrukc_pkg::PATHS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  lrukc_req_if.sink         req,
  lrukc_rsp_if.source       rsp
);

  localparam int LINE_W = $clog2(ENTRIES);

  // lookup stage: holds the accepted request beat
  logic            s1_valid;
  lrukc_pkg::req_t s1_req;
  logic            s1_adv;

  // result stage: flags, with the memory read data held in the store
  logic                  s2_valid;
  lrukc_pkg::rsp_flags_t s2_flags;

  logic                        hit;
  logic                        evict;
  logic [LINE_W-1:0]           line;
  logic [lrukc_pkg::RATE_W-1:0] rd_word;
  logic                        rd_mark;
  logic                        s1_is_set;
  logic                        present;

  // the lookup stage moves on whenever the result stage is empty or draining
  assign s1_adv    = s1_valid && (!s2_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign s1_is_set = (s1_req.req_type == lrukc_pkg::REQ_SET);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req.req_type   <= req.req_type;
      s1_req.entry_key  <= req.entry_key;
      s1_req.path_index <= req.path_index;
      s1_req.rate_in    <= req.rate_in;
    end
  end

  // directory: key match, hit/alloc line choice and recency update
  lrukc_dir #(
    .ENTRIES (ENTRIES),
    .LINE_W  (LINE_W)
  ) u_dir (
    .clk    (clk),
    .rst    (rst),
    .adv    (s1_adv),
    .is_set (s1_is_set),
    .key    (s1_req.entry_key),
    .hit    (hit),
    .evict  (evict),
    .line   (line)
  );

  // rate words and set marks, written or read on the same edge the
  // directory commits, so the next beat always sees this one's effect
  lrukc_store #(
    .ENTRIES (ENTRIES),
    .PATHS   (PATHS),
    .LINE_W  (LINE_W)
  ) u_store (
    .clk     (clk),
    .adv     (s1_adv),
    .req     (s1_req),
    .hit     (hit),
    .line    (line),
    .rd_word (rd_word),
    .rd_mark (rd_mark)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (rsp.ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_flags.found   <= hit;
      s2_flags.is_read <= !s1_is_set;
      s2_flags.evicted <= evict;
    end
  end

  // a read returns data only for a found key with the word's mark set
  assign present          = s2_flags.found && s2_flags.is_read && rd_mark;
  assign rsp.valid        = s2_valid;
  assign rsp.key_found    = s2_flags.found;
  assign rsp.rate_present = present;
  assign rsp.rate_out     = present ? rd_word : '0;
  assign rsp.evicted      = s2_flags.evicted;

endmodule

// File: bench/tb_lru_keyed_rate_cache.sv
// tb_lru_keyed_rate_cache: self-checking bench for the lru keyed rate cache
// predicts every result beat with a behavioural model of the line directory
// depends on lrukc_pkg, lrukc_if and lru_keyed_rate_cache
`timescale 1ns / 1ps

module tb_lru_keyed_rate_cache;

  localparam int N_LINES    = lrukc_pkg::ENTRIES_DEF;
  localparam int N_PATHS    = lrukc_pkg::PATHS_DEF;
  localparam int RAND_ITEMS = 1000;
  localparam int KEY_POOL   = 24;

  // what one response beat should carry
  typedef struct packed {
    logic                         found;
    logic                         present;
    logic [lrukc_pkg::RATE_W-1:0] rate;
    logic                         evicted;
  } rate_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lrukc_req_if req_ch ();
  lrukc_rsp_if rsp_ch ();

  lru_keyed_rate_cache DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow copy of the cache directory and rate store
  logic [lrukc_pkg::KEY_W-1:0]  line_key  [N_LINES];
  bit                           line_vld  [N_LINES];
  int                           line_rank [N_LINES];
  logic [lrukc_pkg::RATE_W-1:0] rate_mem  [N_LINES*N_PATHS];
  bit                           rate_mark [N_LINES*N_PATHS];

  rate_result_t pending_results[$];
  int           fail_count  = 0;
  int           mismatch_no = 0;
  bit           req_gaps_on = 1'b1;
  bit           rsp_gaps_on = 1'b1;
  logic [lrukc_pkg::KEY_W-1:0] key_pool[KEY_POOL];

  // work out the result of one accepted request and advance the shadow state
  function automatic void predict_cache_access(input lrukc_pkg::req_t r);
    int hit_line;
    int victim;
    int oldest;
    int addr;
    rate_result_t res;
    hit_line = -1;
    res      = '0;
    for (int i = 0; i < N_LINES; i++)
      if (line_vld[i] && line_key[i] == r.entry_key && hit_line < 0) hit_line = i;
    res.found = (hit_line >= 0);
    if (r.req_type == lrukc_pkg::REQ_READ) begin
      if (hit_line >= 0) begin
        // lines newer than the hit one age by one, the hit line goes to the front
        for (int i = 0; i < N_LINES; i++)
          if (line_vld[i] && i != hit_line && line_rank[i] < line_rank[hit_line])
            line_rank[i]++;
        line_rank[hit_line] = 0;
        addr = hit_line * N_PATHS + int'(r.path_index);
        if (int'(r.path_index) < N_PATHS && rate_mark[addr]) begin
          res.present = 1'b1;
          res.rate    = rate_mem[addr];
        end
      end
    end else begin
      if (hit_line < 0) begin
        // lowest free line first, otherwise the oldest line is thrown out
        victim = -1;
        for (int i = 0; i < N_LINES; i++)
          if (!line_vld[i] && victim < 0) victim = i;
        if (victim < 0) begin
          res.evicted = 1'b1;
          oldest      = -1;
          victim      = 0;
          for (int i = 0; i < N_LINES; i++)
            if (line_rank[i] >= oldest) begin
              oldest = line_rank[i];
              victim = i;
            end
        end
        for (int i = 0; i < N_LINES; i++)
          if (line_vld[i] && i != victim) line_rank[i]++;
        line_vld[victim]  = 1'b1;
        line_key[victim]  = r.entry_key;
        line_rank[victim] = 0;
        for (int p = 0; p < N_PATHS; p++) rate_mark[victim*N_PATHS + p] = 1'b0;
        hit_line = victim;
      end
      // a set on a present key leaves the recency order alone
      if (int'(r.path_index) < N_PATHS) begin
        addr            = hit_line * N_PATHS + int'(r.path_index);
        rate_mem[addr]  = r.rate_in;
        rate_mark[addr] = 1'b1;
      end
    end
    pending_results.push_back(res);
  endfunction

  // drive one request beat, wait for acceptance, then record the expectation
  task automatic send_req(input logic rtype, input logic [lrukc_pkg::KEY_W-1:0] key,
                          input logic [lrukc_pkg::PIDX_W-1:0] path,
                          input logic [lrukc_pkg::RATE_W-1:0] rate);
    int gap;
    lrukc_pkg::req_t r;
    r.req_type   = rtype;
    r.entry_key  = key;
    r.path_index = path;
    r.rate_in    = rate;
    gap = req_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= r.req_type;
    req_ch.entry_key  <= r.entry_key;
    req_ch.path_index <= r.path_index;
    req_ch.rate_in    <= r.rate_in;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_cache_access(r);
    @(negedge clk);
  endtask

  function automatic logic [lrukc_pkg::RATE_W-1:0] rand_rate();
    case ($urandom_range(0, 9))
      0:       rand_rate = '0;
      1:       rand_rate = '1;
      default: rand_rate = {$urandom, $urandom};
    endcase
  endfunction

  // misses on an empty store, at both ends of the key and path range
  task automatic test_empty_reads();
    send_req(lrukc_pkg::REQ_READ, '0, '0, '1);
    send_req(lrukc_pkg::REQ_READ, '1, '1, '0);
  endtask

  // first sets, read back, unset word in a live line, rewrite of a present key
  task automatic test_fill_and_hit();
    send_req(lrukc_pkg::REQ_SET,  '0, '0, '0);
    send_req(lrukc_pkg::REQ_SET,  '1, '1, '1);
    send_req(lrukc_pkg::REQ_READ, '0, '0, '0);
    send_req(lrukc_pkg::REQ_READ, '1, '1, '0);
    send_req(lrukc_pkg::REQ_READ, '0, '1, '0);
    send_req(lrukc_pkg::REQ_SET,  '0, '0, 64'hA5A5_5A5A_F00D_0FF0);
  endtask

  // fill every line, refresh the first, then force an eviction and probe the victim
  task automatic test_eviction();
    for (int i = 1; i <= N_LINES - 2; i++)
      send_req(lrukc_pkg::REQ_SET, 24'h80_0000 >> i, lrukc_pkg::PIDX_W'(i),
               {$urandom, $urandom});
    send_req(lrukc_pkg::REQ_READ, '0, '0, '0);
    send_req(lrukc_pkg::REQ_SET,  24'h12_3456, 4'h7, '1);
    send_req(lrukc_pkg::REQ_READ, '1, '1, '0);
  endtask

  // mostly keys from a small pool so hits, rewrites and evictions are frequent
  task automatic test_random_traffic();
    logic [lrukc_pkg::KEY_W-1:0] key;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 250 == 0)
        foreach (key_pool[k]) key_pool[k] = lrukc_pkg::KEY_W'($urandom);
      if (n % 50 == 0) begin
        // some stretches run flat out on one or both sides
        req_gaps_on = ($urandom_range(0, 3) != 0);
        rsp_gaps_on = ($urandom_range(0, 3) != 0);
      end
      key = ($urandom_range(0, 9) == 0) ? lrukc_pkg::KEY_W'($urandom)
                                        : key_pool[$urandom_range(0, KEY_POOL - 1)];
      send_req(($urandom_range(0, 99) < 45) ? lrukc_pkg::REQ_READ : lrukc_pkg::REQ_SET,
               key, lrukc_pkg::PIDX_W'($urandom_range(0, 15)), rand_rate());
    end
    req_gaps_on = 1'b1;
    rsp_gaps_on = 1'b1;
  endtask

  // response side back-pressure, redrawn for every beat
  initial begin : rsp_ready_driver
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = rsp_gaps_on ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // compare every accepted result beat with the oldest expectation
  always @(posedge clk) begin
    rate_result_t want;
    rate_result_t got;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = '{rsp_ch.key_found, rsp_ch.rate_present, rsp_ch.rate_out, rsp_ch.evicted};
      if (pending_results.size() == 0) begin
        fail_count++;
        mismatch_no++;
        if (mismatch_no <= 10)
          $display("unexpected result beat: found=%0b present=%0b rate=%h evicted=%0b",
                   got.found, got.present, got.rate, got.evicted);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          mismatch_no++;
          if (mismatch_no <= 10)
            $display({"mismatch: exp found=%0b present=%0b rate=%h evicted=%0b",
                      " / got %0b %0b %h %0b"},
                     want.found, want.present, want.rate, want.evicted,
                     got.found, got.present, got.rate, got.evicted);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    req_ch.valid      = 1'b0;
    req_ch.req_type   = lrukc_pkg::REQ_READ;
    req_ch.entry_key  = '0;
    req_ch.path_index = '0;
    req_ch.rate_in    = '0;
    foreach (line_vld[i]) begin
      line_vld[i]  = 1'b0;
      line_rank[i] = 0;
      line_key[i]  = '0;
    end
    foreach (rate_mark[i]) begin
      rate_mark[i] = 1'b0;
      rate_mem[i]  = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_reads();
    test_fill_and_hit();
    test_eviction();
    test_random_traffic();

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
